>>> rtl/rbd_pkg.sv
// rbd_pkg: shared types and constants for the ring buffer deque
// no dependencies
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int OCC_W         = 7;
    localparam int STATUS_W      = 2;
    localparam int CMD_W         = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_L = 3'd0,
        CMD_PUSH_R = 3'd1,
        CMD_POP_L  = 3'd2,
        CMD_POP_R  = 3'd3,
        CMD_PEEK_L = 3'd4,
        CMD_PEEK_R = 3'd5,
        CMD_DUMP   = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_t;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] word;
        logic                     last;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
        logic                     is_full;
    } rsp_t;

    typedef struct packed {
        logic push_l;
        logic push_r;
        logic pop_l;
        logic pop_r;
        logic clear;
    } ptr_op_t;

endpackage

>>> rtl/ring_buffer_deque.sv
// ring_buffer_deque: push, pop, peek, dump and clear on a circular word store.
// every command gives its first result beat in the cycle after it is accepted.
// push, pop, peek and clear can be accepted back to back while busy is low;
// a dump of n words holds busy until all n words are read, one ram read per beat.
// reset clears pointers and count at once; the store keeps its contents.
// depends on rbd_pkg, rbd_ram, rbd_ptr
`timescale 1ns / 1ps

module ring_buffer_deque #(
    parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rbd_pkg::req_t request,
    output logic          strobe,
    output rbd_pkg::rsp_t result
);

    import rbd_pkg::*;

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       dump_ptr_reg;
    logic [CW-1:0]       left_reg;
    logic                strobe_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;
    logic                from_ram_reg;

    logic          accept;
    cmd_t          cmd;
    logic          empty;
    logic          full;
    ptr_op_t       op;
    logic [AW-1:0] head, head_prev, head_succ, tail, tail_prev;
    logic [CW-1:0] count;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [AW-1:0] dump_succ;

    assign accept = start && (state_reg == S_IDLE);
    assign cmd    = cmd_t'(request.command);
    assign empty  = (count == '0);
    assign full   = (count == CW'(DEPTH));

    always_comb
    begin
        op.push_l = accept && (cmd == CMD_PUSH_L) && !full;
        op.push_r = accept && (cmd == CMD_PUSH_R) && !full;
        op.pop_l  = accept && (cmd == CMD_POP_L) && !empty;
        op.pop_r  = accept && (cmd == CMD_POP_R) && !empty;
        op.clear  = accept && (cmd == CMD_CLEAR);
    end

    rbd_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .head     (head),
        .head_prev(head_prev),
        .head_succ(head_succ),
        .tail     (tail),
        .tail_prev(tail_prev),
        .count    (count)
    );

    // one command per cycle, none while busy, so a write always lands before the next read
    assign wr_en   = op.push_l || op.push_r;
    assign wr_addr = op.push_l ? head_prev : tail;
    assign rd_en   = (state_reg == S_DUMP) ||
                     (accept && (cmd == CMD_PEEK_L || cmd == CMD_PEEK_R || cmd == CMD_DUMP));
    assign rd_addr = (state_reg == S_DUMP) ? dump_ptr_reg :
                     (cmd == CMD_PEEK_R) ? tail_prev : head;

    rbd_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(request.value),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign dump_succ = (dump_ptr_reg == LAST_IDX) ? '0 : dump_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dump_ptr_reg <= '0;
            left_reg     <= '0;
            strobe_reg   <= 1'b0;
            status_reg   <= STATUS_OK;
            last_reg     <= 1'b0;
            from_ram_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        strobe_reg   <= 1'b1;
                        last_reg     <= 1'b1;
                        status_reg   <= STATUS_OK;
                        from_ram_reg <= 1'b0;
                        case (cmd) inside
                            CMD_PUSH_L, CMD_PUSH_R:
                            begin
                                if (full)
                                begin
                                    status_reg <= STATUS_FULL;
                                end
                            end
                            CMD_POP_L, CMD_POP_R:
                            begin
                                if (empty)
                                begin
                                    status_reg <= STATUS_EMPTY;
                                end
                            end
                            CMD_PEEK_L, CMD_PEEK_R:
                            begin
                                if (empty)
                                begin
                                    status_reg <= STATUS_EMPTY;
                                end
                                else
                                begin
                                    from_ram_reg <= 1'b1;
                                end
                            end
                            CMD_DUMP:
                            begin
                                if (empty)
                                begin
                                    status_reg <= STATUS_EMPTY;
                                end
                                else
                                begin
                                    from_ram_reg <= 1'b1;
                                    last_reg     <= (count == CW'(1));
                                    dump_ptr_reg <= head_succ;
                                    left_reg     <= count - 1'b1;
                                    if (count != CW'(1))
                                    begin
                                        state_reg <= S_DUMP;
                                    end
                                end
                            end
                            default:
                            begin
                                status_reg <= STATUS_OK;
                            end
                        endcase
                    end
                end
                S_DUMP:
                begin
                    strobe_reg   <= 1'b1;
                    status_reg   <= STATUS_OK;
                    from_ram_reg <= 1'b1;
                    last_reg     <= (left_reg == CW'(1));
                    dump_ptr_reg <= dump_succ;
                    left_reg     <= left_reg - 1'b1;
                    if (left_reg == CW'(1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg == S_DUMP);
    assign strobe = strobe_reg;

    always_comb
    begin
        result.status    = status_reg;
        result.word      = from_ram_reg ? rd_data : '0;
        result.last      = last_reg;
        result.occupancy = OCC_W'(count);
        result.is_empty  = empty;
        result.is_full   = full;
    end

endmodule

>>> rtl/rbd_ram.sv
// rbd_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/rbd_ptr.sv
// rbd_ptr: front and rear pointers and occupancy count, wrapping modulo depth
// depends on rbd_pkg
`timescale 1ns / 1ps

module rbd_ptr #(
    parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rbd_pkg::ptr_op_t op,
    output logic [AW-1:0]   head,
    output logic [AW-1:0]   head_prev,
    output logic [AW-1:0]   head_succ,
    output logic [AW-1:0]   tail,
    output logic [AW-1:0]   tail_prev,
    output logic [CW-1:0]   count
);

    import rbd_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] tail_succ;

    assign head_prev = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign head_succ = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_prev = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign tail_succ = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (op.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (op.push_l)
        begin
            head_next  = head_prev;
            count_next = count_reg + 1'b1;
        end
        else if (op.push_r)
        begin
            tail_next  = tail_succ;
            count_next = count_reg + 1'b1;
        end
        else if (op.pop_l)
        begin
            head_next  = head_succ;
            count_next = count_reg - 1'b1;
        end
        else if (op.pop_r)
        begin
            tail_next  = tail_prev;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head  = head_reg;
    assign tail  = tail_reg;
    assign count = count_reg;

endmodule

>>> rtl/rbd_checker.sv
// rbd_checker: port-level checks on the ring buffer deque, bound to the top level
// depends on rbd_pkg, ring_buffer_deque
`timescale 1ns / 1ps

module rbd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input rbd_pkg::req_t request,
    input logic          strobe,
    input rbd_pkg::rsp_t result
);

    import rbd_pkg::*;

    // every single-beat command ends on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.command != CMD_DUMP |=> strobe && result.last)
    else $error("single-beat command did not finish next cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.command == CMD_DUMP |=> strobe)
    else $error("dump gave no beat");

    // while a dump walks, each cycle is a non-final beat
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> strobe && !result.last)
    else $error("dump beat missing or marked last early");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && result.last)
    else $error("dump did not end with a last beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.is_empty == (result.occupancy == '0)) &&
                   !(result.is_empty && result.is_full))
    else $error("occupancy flags inconsistent");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .request(request),
    .strobe (strobe),
    .result (result)
);
